### hdl/acsd_pkg.sv
package acsd_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 24;
    localparam int STABLE_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int PHASE_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE = 2'd2;

    localparam logic [CFG_W-1:0]    HOLD_RST   = 24'd5000;
    localparam logic [CFG_W-1:0]    WINDOW_RST = 24'd20000;
    localparam logic [STABLE_W-1:0] STABLE_RST = 4'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT_BLACK   = 3'd0,
        PH_SAMPLE_BLACK = 3'd1,
        PH_WAIT_YELLOW  = 3'd2,
        PH_SAMPLE_YELLOW = 3'd3,
        PH_MONITOR      = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_BDIV,
        ST_YDIV,
        ST_CAL,
        ST_SETTLE,
        ST_EMIT
    } t_state;

endpackage

### hdl/acsd_if.sv
interface acsd_in_if import acsd_pkg::*; #(parameter int SAMPLE_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_W-1:0]      time_ms;

    modport source (output valid, sample, time_ms, input ready);
    modport sink   (input valid, sample, time_ms, output ready);
endinterface

interface acsd_out_if import acsd_pkg::*; #(parameter int SAMPLE_BITS = 10);
    logic                   valid;
    logic                   ready;
    logic [PHASE_W-1:0]     phase_now;
    logic                   on_yellow;
    logic                   surface_changed;
    logic [SAMPLE_BITS-1:0] level_threshold;
    logic                   yellow_brighter;
    logic [SAMPLE_BITS-1:0] black_level;
    logic [SAMPLE_BITS-1:0] yellow_level;

    modport source (output valid, phase_now, on_yellow, surface_changed, level_threshold,
                    yellow_brighter, black_level, yellow_level, input ready);
    modport sink   (input valid, phase_now, on_yellow, surface_changed, level_threshold,
                    yellow_brighter, black_level, yellow_level, output ready);
endinterface

interface acsd_cfg_if import acsd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/acsd_div.sv
module acsd_div #(
    parameter int COUNT_BITS  = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [COUNT_BITS+SAMPLE_BITS-1:0] i_dividend,
    input  logic [COUNT_BITS-1:0]             i_divisor,
    output logic                              o_done,
    output logic [SAMPLE_BITS-1:0]            o_quot
);
    // Restoring divide; quotient fits SAMPLE_BITS since dividend < divisor << SAMPLE_BITS.
    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    logic [COUNT_BITS-1:0]  r_rem;
    logic [SAMPLE_BITS-1:0] r_low;
    logic [COUNT_BITS-1:0]  r_den;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [COUNT_BITS:0]    trial;
    logic [COUNT_BITS:0]    shifted;
    logic                   qbit;

    always_comb begin
        shifted = {r_rem, r_low[SAMPLE_BITS-1]};
        trial   = shifted - {1'b0, r_den};
        qbit    = ~trial[COUNT_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SAMPLE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[COUNT_BITS+SAMPLE_BITS-1:SAMPLE_BITS];
            r_low <= i_dividend[SAMPLE_BITS-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            r_low <= {r_low[SAMPLE_BITS-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

### hdl/auto_calibrating_surface_detector.sv
// Surface detector with two-level self calibration. Each input word carries one
// reflectance sample and a millisecond timestamp and yields exactly one output word.
// An ordinary word passes from acceptance through phase update to the output register
// load, which waits until the output register is free. For the word that closes the
// yellow window, one shared restoring divider first computes the black mean and
// then the yellow mean, one quotient bit per cycle, before the threshold, polarity
// and starting surface are set. The input is not ready until the output register
// has taken the word's result. Configuration writes are always accepted and belong
// in idle periods.
module auto_calibrating_surface_detector import acsd_pkg::*; #(
    parameter int COUNT_BITS  = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acsd_in_if.sink     i_in,
    acsd_cfg_if.sink    i_cfg,
    acsd_out_if.source  o_out
);
    localparam int SUM_W = COUNT_BITS + SAMPLE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_hold;
    logic [CFG_W-1:0]    r_window;
    logic [STABLE_W-1:0] r_stable;

    logic [SAMPLE_BITS-1:0] r_smp;
    logic [TIME_W-1:0]      r_time;

    t_phase                 r_phase,   n_phase;
    logic [TIME_W-1:0]      r_start,   n_start;
    logic [SUM_W-1:0]       r_bsum,    n_bsum;
    logic [COUNT_BITS-1:0]  r_bcnt,    n_bcnt;
    logic [SUM_W-1:0]       r_ysum,    n_ysum;
    logic [COUNT_BITS-1:0]  r_ycnt,    n_ycnt;
    logic [SAMPLE_BITS-1:0] r_bmean,   n_bmean;
    logic [SAMPLE_BITS-1:0] r_ymean,   n_ymean;
    logic [SAMPLE_BITS-1:0] r_thr,     n_thr;
    logic                   r_pol,     n_pol;
    logic                   r_surf,    n_surf;
    logic                   r_cand,    n_cand;
    logic [STABLE_W-1:0]    r_run,     n_run;
    logic                   r_changed, n_changed;

    logic                   r_out_valid;
    logic [PHASE_W-1:0]     r_out_phase;
    logic                   r_out_surf;
    logic                   r_out_changed;
    logic [SAMPLE_BITS-1:0] r_out_thr;
    logic                   r_out_pol;
    logic [SAMPLE_BITS-1:0] r_out_bmean;
    logic [SAMPLE_BITS-1:0] r_out_ymean;

    logic                   in_ready;
    logic                   out_free;
    logic                   out_load;
    logic                   div_start;
    logic                   div_sel_y;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_quot;
    logic [SUM_W-1:0]       div_num;
    logic [COUNT_BITS-1:0]  div_den;

    logic [TIME_W-1:0]      elapsed;
    logic                   hold_hit;
    logic                   win_hit;
    logic                   end_cal;
    logic                   guess;
    logic [STABLE_W:0]      run_inc;
    logic [STABLE_W-1:0]    run_new;
    logic [SAMPLE_BITS:0]   mean_sum;

    always_comb begin
        elapsed  = r_time - r_start;
        hold_hit = elapsed >= TIME_W'(r_hold);
        win_hit  = elapsed >= TIME_W'(r_window);
        end_cal  = (r_phase == PH_SAMPLE_YELLOW) && win_hit;
        guess    = r_pol ? (r_smp >= r_thr) : (r_smp <= r_thr);
        out_free = !r_out_valid || o_out.ready;
        div_num  = div_sel_y ? r_ysum : r_bsum;
        div_den  = div_sel_y ? r_ycnt : r_bcnt;
    end

    acsd_div #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = end_cal ? ST_BDIV : ST_EMIT;
            end
            ST_BDIV: begin
                if (div_done) begin
                    n_state = ST_YDIV;
                end
            end
            ST_YDIV: begin
                if (div_done) begin
                    n_state = ST_CAL;
                end
            end
            ST_CAL: begin
                n_state = ST_SETTLE;
            end
            ST_SETTLE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        div_sel_y = (r_state == ST_BDIV);
        div_start = ((r_state == ST_STEP) && end_cal) || ((r_state == ST_BDIV) && div_done);
        out_load  = (r_state == ST_EMIT) && out_free;
    end

    // phase datapath
    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        n_bsum    = r_bsum;
        n_bcnt    = r_bcnt;
        n_ysum    = r_ysum;
        n_ycnt    = r_ycnt;
        n_bmean   = r_bmean;
        n_ymean   = r_ymean;
        n_thr     = r_thr;
        n_pol     = r_pol;
        n_surf    = r_surf;
        n_cand    = r_cand;
        n_run     = r_run;
        n_changed = r_changed;
        run_inc   = {1'b0, r_run} + (STABLE_W+1)'(1);
        run_new   = r_run;
        mean_sum  = {1'b0, r_bmean} + {1'b0, r_ymean};
        case (r_state)
            ST_STEP: begin
                n_changed = 1'b0;
                case (r_phase)
                    PH_WAIT_BLACK: begin
                        if (hold_hit) begin
                            n_phase = PH_SAMPLE_BLACK;
                            n_start = r_time;
                            n_bsum  = '0;
                            n_bcnt  = '0;
                        end
                    end
                    PH_SAMPLE_BLACK: begin
                        if (r_bcnt != COUNT_MAX) begin
                            n_bsum = r_bsum + SUM_W'(r_smp);
                            n_bcnt = r_bcnt + COUNT_BITS'(1);
                        end
                        if (win_hit) begin
                            n_phase = PH_WAIT_YELLOW;
                            n_start = r_time;
                        end
                    end
                    PH_WAIT_YELLOW: begin
                        if (hold_hit) begin
                            n_phase = PH_SAMPLE_YELLOW;
                            n_start = r_time;
                            n_ysum  = '0;
                            n_ycnt  = '0;
                        end
                    end
                    PH_SAMPLE_YELLOW: begin
                        if (r_ycnt != COUNT_MAX) begin
                            n_ysum = r_ysum + SUM_W'(r_smp);
                            n_ycnt = r_ycnt + COUNT_BITS'(1);
                        end
                    end
                    default: begin
                        if (guess == r_cand) begin
                            run_new = (run_inc < {1'b0, r_stable}) ? run_inc[STABLE_W-1:0]
                                                                   : r_stable;
                        end else begin
                            run_new = STABLE_W'(1);
                        end
                        n_cand = guess;
                        n_run  = run_new;
                        if ((run_new >= r_stable) && (guess != r_surf)) begin
                            n_surf    = guess;
                            n_changed = 1'b1;
                        end
                    end
                endcase
            end
            ST_BDIV: begin
                if (div_done) begin
                    n_bmean = (r_bcnt == '0) ? '0 : div_quot;
                end
            end
            ST_YDIV: begin
                if (div_done) begin
                    n_ymean = (r_ycnt == '0) ? '0 : div_quot;
                end
            end
            ST_CAL: begin
                n_pol = r_ymean > r_bmean;
                n_thr = mean_sum[SAMPLE_BITS:1];
            end
            ST_SETTLE: begin
                n_surf  = guess;
                n_cand  = guess;
                n_run   = '0;
                n_phase = PH_MONITOR;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_WAIT_BLACK;
            r_start     <= '0;
            r_bsum      <= '0;
            r_bcnt      <= '0;
            r_ysum      <= '0;
            r_ycnt      <= '0;
            r_bmean     <= '0;
            r_ymean     <= '0;
            r_thr       <= '0;
            r_pol       <= 1'b1;
            r_surf      <= 1'b0;
            r_cand      <= 1'b0;
            r_run       <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_bsum    <= n_bsum;
            r_bcnt    <= n_bcnt;
            r_ysum    <= n_ysum;
            r_ycnt    <= n_ycnt;
            r_bmean   <= n_bmean;
            r_ymean   <= n_ymean;
            r_thr     <= n_thr;
            r_pol     <= n_pol;
            r_surf    <= n_surf;
            r_cand    <= n_cand;
            r_run     <= n_run;
            r_changed <= n_changed;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_smp  <= i_in.sample;
            r_time <= i_in.time_ms;
        end
        if (out_load) begin
            r_out_phase   <= r_phase;
            r_out_surf    <= r_surf;
            r_out_changed <= r_changed;
            r_out_thr     <= r_thr;
            r_out_pol     <= r_pol;
            r_out_bmean   <= r_bmean;
            r_out_ymean   <= r_ymean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= HOLD_RST;
            r_window <= WINDOW_RST;
            r_stable <= STABLE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HOLD: begin
                    r_hold <= i_cfg.data;
                end
                CFG_WINDOW: begin
                    r_window <= i_cfg.data;
                end
                CFG_STABLE: begin
                    r_stable <= i_cfg.data[STABLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready            = in_ready;
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.phase_now       = r_out_phase;
    assign o_out.on_yellow       = r_out_surf;
    assign o_out.surface_changed = r_out_changed;
    assign o_out.level_threshold = r_out_thr;
    assign o_out.yellow_brighter = r_out_pol;
    assign o_out.black_level     = r_out_bmean;
    assign o_out.yellow_level    = r_out_ymean;

endmodule
